// ===== hw/rtl/ptw_pkg.sv =====
// ============================================================================
// ptw_pkg
// Shared types and constants for the four-level page table walker.
// ============================================================================
package ptw_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int ROOT_W  = 40;
    localparam int VADDR_W = 48;
    localparam int PADDR_W = 52;
    localparam int ENTRY_W = 64;

    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_REPLY     = 1'b1;

    localparam logic KIND_FETCH = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    localparam logic CFG_ROOT_TABLE_FRAME = 1'b0;
    localparam logic CFG_USER_ONLY        = 1'b1;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NOT_PRESENT  = 3'd1;
    localparam logic [2:0] ST_SUPERVISOR   = 3'd2;
    localparam logic [2:0] ST_RESERVED     = 3'd3;
    localparam logic [2:0] ST_TOP_LARGE    = 3'd4;
    localparam logic [2:0] ST_UNREADABLE   = 3'd5;

    localparam logic [2:0] LVL_NONE = 3'd0;
    localparam logic [2:0] LVL_1    = 3'd1;
    localparam logic [2:0] LVL_2    = 3'd2;
    localparam logic [2:0] LVL_3    = 3'd3;
    localparam logic [2:0] LVL_4    = 3'd4;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_USER    = 2;
    localparam int BIT_PS      = 7;

    typedef struct packed {
        logic                 cmd;
        logic [VADDR_W-1:0]   virt_addr;
        logic [ENTRY_W-1:0]   entry_data;
        logic                 fetch_ok;
    } req_t;

    typedef struct packed {
        logic                 kind;
        logic [PADDR_W-1:0]   fetch_addr;
        logic [PADDR_W-1:0]   phys_addr;
        logic [2:0]           status;
        logic [2:0]           end_level;
    } rsp_t;

    // classified word between front and back
    typedef struct packed {
        logic                 kind;
        logic [2:0]           status;
        logic [2:0]           level;
        logic [ROOT_W-1:0]    frame;
        logic [VADDR_W-1:0]   vaddr;
    } work_t;

endpackage

// ===== hw/rtl/ptw_front.sv =====
// ============================================================================
// ptw_front
// Accepts words, runs the walk state and classifies each reply.
// ============================================================================
module ptw_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [ptw_pkg::ROOT_W-1:0] cfg_data,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  ptw_pkg::req_t              req,
    output logic                       push_valid,
    input  logic                       push_ready,
    output ptw_pkg::work_t             push_word
);
    import ptw_pkg::*;

    logic [ROOT_W-1:0]  root_reg;
    logic               user_only_reg;
    logic               busy_reg,  busy_next;
    logic [2:0]         level_reg, level_next;
    logic [VADDR_W-1:0] vaddr_reg, vaddr_next;
    logic               accept;
    logic [2:0]         fail;
    logic               leaf;

    assign req_ready = push_ready;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        priority if (!req.fetch_ok)
            fail = ST_UNREADABLE;
        else if (!req.entry_data[BIT_PRESENT])
            fail = ST_NOT_PRESENT;
        else if (user_only_reg && !req.entry_data[BIT_USER])
            fail = ST_SUPERVISOR;
        else if (req.entry_data[51:48] != 4'd0)
            fail = ST_RESERVED;
        else if ((level_reg == LVL_4) && req.entry_data[BIT_PS])
            fail = ST_TOP_LARGE;
        else
            fail = ST_OK;
    end

    assign leaf = (level_reg == LVL_1) || req.entry_data[BIT_PS];

    always_comb
    begin
        push_valid        = 1'b0;
        push_word.kind    = KIND_FETCH;
        push_word.status  = ST_OK;
        push_word.level   = level_reg;
        push_word.frame   = {4'd0, req.entry_data[47:12]};
        push_word.vaddr   = vaddr_reg;
        busy_next         = busy_reg;
        level_next        = level_reg;
        vaddr_next        = vaddr_reg;
        if (req_valid)
        begin
            unique case (req.cmd)
                CMD_TRANSLATE:
                begin
                    if (!busy_reg)
                    begin
                        push_valid      = 1'b1;
                        push_word.level = LVL_4;
                        push_word.frame = root_reg;
                        push_word.vaddr = req.virt_addr;
                        busy_next       = 1'b1;
                        level_next      = LVL_4;
                        vaddr_next      = req.virt_addr;
                    end
                end
                CMD_REPLY:
                begin
                    if (busy_reg)
                    begin
                        push_valid = 1'b1;
                        if (fail != ST_OK || leaf)
                        begin
                            push_word.kind   = KIND_DONE;
                            push_word.status = fail;
                            busy_next        = 1'b0;
                            level_next       = LVL_NONE;
                        end
                        else
                        begin
                            push_word.level = level_reg - 3'd1;
                            level_next      = level_reg - 3'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg      <= '0;
            user_only_reg <= 1'b0;
            busy_reg      <= 1'b0;
            level_reg     <= LVL_NONE;
            vaddr_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ROOT_TABLE_FRAME: root_reg      <= cfg_data;
                    CFG_USER_ONLY:        user_only_reg <= cfg_data[0];
                    default:              root_reg      <= root_reg;
                endcase
            end
            if (accept)
            begin
                busy_reg  <= busy_next;
                level_reg <= level_next;
                vaddr_reg <= vaddr_next;
            end
        end
    end

endmodule

// ===== hw/rtl/ptw_queue.sv =====
// ============================================================================
// ptw_queue
// Short FIFO of classified words between front and back.
// ============================================================================
module ptw_queue #(
    parameter int DEPTH = ptw_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  ptw_pkg::work_t push_word,
    output logic           pop_valid,
    input  logic           pop_ready,
    output ptw_pkg::work_t pop_word
);
    import ptw_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    work_t         mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== hw/rtl/ptw_back.sv =====
// ============================================================================
// ptw_back
// Forms fetch and physical addresses and holds the output register.
// ============================================================================
module ptw_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  ptw_pkg::work_t pop_word,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ptw_pkg::rsp_t  rsp
);
    import ptw_pkg::*;

    logic               rsp_valid_reg;
    rsp_t               rsp_reg, rsp_next;
    logic [8:0]         idx;
    logic [PADDR_W-1:0] low_mask;
    logic [PADDR_W-1:0] frame_addr;

    assign pop_ready = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        unique case (pop_word.level)
            LVL_2:   idx = pop_word.vaddr[29:21];
            LVL_3:   idx = pop_word.vaddr[38:30];
            LVL_4:   idx = pop_word.vaddr[47:39];
            default: idx = pop_word.vaddr[20:12];
        endcase
        unique case (pop_word.level)
            LVL_2:   low_mask = PADDR_W'({21{1'b1}});
            LVL_3:   low_mask = PADDR_W'({30{1'b1}});
            default: low_mask = PADDR_W'({12{1'b1}});
        endcase
    end

    assign frame_addr = {pop_word.frame, 12'd0};

    always_comb
    begin
        rsp_next.kind       = pop_word.kind;
        rsp_next.status     = pop_word.status;
        rsp_next.end_level  = pop_word.level;
        rsp_next.fetch_addr = '0;
        rsp_next.phys_addr  = '0;
        unique case (pop_word.kind)
            KIND_FETCH:
                rsp_next.fetch_addr = {pop_word.frame, idx, 3'd0};
            KIND_DONE:
            begin
                if (pop_word.status == ST_OK)
                    rsp_next.phys_addr = (frame_addr & ~low_mask)
                                       | ({4'd0, pop_word.vaddr} & low_mask);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (pop_ready)
            rsp_valid_reg <= pop_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pop_ready && pop_valid)
            rsp_reg <= rsp_next;
    end

endmodule

// ===== hw/rtl/x64_page_table_walker_unit.sv =====
// ============================================================================
// x64_page_table_walker_unit
// Four-level x86-64 page table walker: front classifier, queue, back end.
// ============================================================================
//  channel | handshake             | word
//  --------+-----------------------+----------------------------------------
//  req     | req_valid / req_ready | cmd, virt_addr, entry_data, fetch_ok
//  rsp     | rsp_valid / rsp_ready | kind, fetch_addr, phys_addr, status, lvl
//  cfg     | cfg_we                | cfg_index, cfg_data (no read-back)
//
// One word per cycle sustained while the queue has room; a result is registered
// in the queue and then in the output register before it leaves.
// Reset clears the walk state, the queue and the output valid; no sweep.
// A stall on rsp fills the queue, after which req_ready drops.
// Words that produce no result (ignored requests and replies) never enter the queue.
module x64_page_table_walker_unit #(
    parameter int QUEUE_DEPTH = ptw_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [ptw_pkg::ROOT_W-1:0] cfg_data,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  ptw_pkg::req_t              req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output ptw_pkg::rsp_t              rsp
);
    import ptw_pkg::*;

    logic  push_valid;
    logic  push_ready;
    work_t push_word;
    logic  pop_valid;
    logic  pop_ready;
    work_t pop_word;

    ptw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    ptw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    ptw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_word  (pop_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ===== tb/ptw_walk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_walk_checker
// Passive checker for the page table walker. It follows the register writes,
// keeps its own copy of the walk state, predicts the word that each accepted
// request or entry reply produces and compares every result word with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module ptw_walk_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [ptw_pkg::ROOT_W-1:0] cfg_data,
    input  logic                       req_valid,
    input  logic                       req_ready,
    input  ptw_pkg::req_t              req,
    input  logic                       rsp_valid,
    input  logic                       rsp_ready,
    input  ptw_pkg::rsp_t              rsp,
    output int                         fail_count,
    output int                         pending_count,
    output int                         result_words,
    output int                         checked_count,
    output logic [7:0]                 status_seen,
    output logic [7:0]                 level_seen
);

    import ptw_pkg::*;

    logic [ROOT_W-1:0]  root_frame;
    logic               user_only_mode;
    logic               walk_busy;
    logic [2:0]         walk_level;
    logic [VADDR_W-1:0] walk_vaddr;
    rsp_t               walk_results_q[$];
    rsp_t               predicted;
    rsp_t               oldest;
    int                 n_fail;
    int                 n_words;
    int                 n_checked;
    logic [7:0]         st_seen;
    logic [7:0]         lv_seen;

    function automatic int level_shift(input logic [2:0] lvl);
        case (lvl)
            LVL_4:   return 39;
            LVL_3:   return 30;
            LVL_2:   return 21;
            default: return 12;
        endcase
    endfunction

    function automatic bit walk_step(input req_t w, output rsp_t r);
        logic [2:0]         lvl;
        logic [8:0]         idx;
        logic [PADDR_W-1:0] frame;
        logic [PADDR_W-1:0] low;
        r     = '0;
        lvl   = walk_level;
        frame = {4'b0, w.entry_data[47:12], 12'b0};
        if (w.cmd == CMD_TRANSLATE)
        begin
            if (walk_busy)
                return 1'b0;
            walk_busy    = 1'b1;
            walk_level   = LVL_4;
            walk_vaddr   = w.virt_addr;
            r.kind       = KIND_FETCH;
            r.fetch_addr = {root_frame, w.virt_addr[47:39], 3'b000};
            r.end_level  = LVL_4;
            return 1'b1;
        end
        if (!walk_busy)
            return 1'b0;
        if (lvl < LVL_1 || lvl > LVL_4)
            lvl = LVL_1;
        r.kind      = KIND_DONE;
        r.end_level = lvl;
        if (!w.fetch_ok)
            r.status = ST_UNREADABLE;
        else if (!w.entry_data[BIT_PRESENT])
            r.status = ST_NOT_PRESENT;
        else if (user_only_mode && !w.entry_data[BIT_USER])
            r.status = ST_SUPERVISOR;
        else if (w.entry_data[51:48] != 4'h0)
            r.status = ST_RESERVED;
        else if (lvl == LVL_4 && w.entry_data[BIT_PS])
            r.status = ST_TOP_LARGE;
        else if (lvl == LVL_1 || w.entry_data[BIT_PS])
        begin
            low         = (52'd1 << level_shift(lvl)) - 52'd1;
            r.phys_addr = (frame & ~low) | ({4'b0, walk_vaddr} & low);
        end
        else
        begin
            lvl          = lvl - 3'd1;
            idx          = walk_vaddr[level_shift(lvl) +: 9];
            walk_level   = lvl;
            r.kind       = KIND_FETCH;
            r.fetch_addr = frame + {idx, 3'b000};
            r.end_level  = lvl;
            return 1'b1;
        end
        walk_busy  = 1'b0;
        walk_level = LVL_NONE;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t ptw: %s mismatch, expected %0h got %0h", $time, name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_frame     = '0;
            user_only_mode = 1'b0;
            walk_busy      = 1'b0;
            walk_level     = LVL_NONE;
            walk_vaddr     = '0;
            walk_results_q.delete();
            n_fail         = 0;
            n_words        = 0;
            n_checked      = 0;
            st_seen        = '0;
            lv_seen        = '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ROOT_TABLE_FRAME)
                    root_frame = cfg_data;
                else
                    user_only_mode = cfg_data[0];
            end
            if (rsp_valid && rsp_ready)
            begin
                if (walk_results_q.size() == 0)
                begin
                    $display("%0t ptw: unexpected result word, expected none got %0h",
                             $time, rsp);
                    n_fail++;
                end
                else
                begin
                    oldest = walk_results_q.pop_front();
                    check_field("kind", 64'(oldest.kind), 64'(rsp.kind));
                    check_field("fetch_addr", 64'(oldest.fetch_addr), 64'(rsp.fetch_addr));
                    check_field("phys_addr", 64'(oldest.phys_addr), 64'(rsp.phys_addr));
                    check_field("status", 64'(oldest.status), 64'(rsp.status));
                    check_field("end_level", 64'(oldest.end_level), 64'(rsp.end_level));
                    n_checked++;
                end
            end
            if (req_valid && req_ready)
            begin
                if (walk_step(req, predicted))
                begin
                    walk_results_q.push_back(predicted);
                    n_words++;
                    if (predicted.kind == KIND_DONE)
                        st_seen[predicted.status] = 1'b1;
                    lv_seen[predicted.end_level] = 1'b1;
                end
            end
        end
        fail_count    <= n_fail;
        pending_count <= walk_results_q.size();
        result_words  <= n_words;
        checked_count <= n_checked;
        status_seen   <= st_seen;
        level_seen    <= lv_seen;
    end

endmodule

// ===== tb/tb_x64_page_table_walker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_x64_page_table_walker_unit
// Drives the page table walker with a short set of hand-made walks covering
// every exit status and page size, then with random walks under a range of
// root frames and user-only settings, with random stalls on both channels.
// Prediction and comparison sit in ptw_walk_checker.
// ----------------------------------------------------------------------------
module tb_x64_page_table_walker_unit;

    import ptw_pkg::*;

    localparam int ITEMS_PER_PHASE = 305;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_CYCLES     = 400;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_index;
    logic [ROOT_W-1:0] cfg_data;
    logic              req_valid;
    logic              req_ready;
    req_t              req;
    logic              rsp_valid;
    logic              rsp_ready;
    rsp_t              rsp;

    int                fail_count;
    int                pending_count;
    int                result_words;
    int                checked_count;
    logic [7:0]        status_seen;
    logic [7:0]        level_seen;

    bit                steady;
    bit                user_only_now;

    x64_page_table_walker_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    ptw_walk_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_words  (result_words),
        .checked_count (checked_count),
        .status_seen   (status_seen),
        .level_seen    (level_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 16);
        return $urandom_range(20, 80);
    endfunction

    function automatic req_t translate_word(input logic [VADDR_W-1:0] va);
        req_t w;
        w.cmd        = CMD_TRANSLATE;
        w.virt_addr  = va;
        w.entry_data = rand64();
        w.fetch_ok   = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic req_t reply_word(input logic [ENTRY_W-1:0] e, input bit ok);
        req_t w;
        w.cmd        = CMD_REPLY;
        w.virt_addr  = VADDR_W'(rand64());
        w.entry_data = e;
        w.fetch_ok   = ok;
        return w;
    endfunction

    task automatic send_word(input req_t w);
        int gap;
        gap = steady ? 0 : idle_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_config(input logic [ROOT_W-1:0] root, input bit uo);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROOT_TABLE_FRAME;
        cfg_data  <= root;
        @(posedge clk);
        cfg_index <= CFG_USER_ONLY;
        cfg_data  <= {{(ROOT_W-1){1'b0}}, uo};
        @(posedge clk);
        cfg_we    <= 1'b0;
        user_only_now = uo;
    endtask

    task automatic directed_walks();
        load_config('1, 1'b0);
        steady = 1'b0;
        send_word(translate_word(48'h0));
        send_word(reply_word('1, 1'b0));
        send_word(reply_word('1, 1'b1));
        send_word(translate_word('1));
        send_word(translate_word(48'h0));
        send_word(reply_word(~64'h1, 1'b1));
        send_word(translate_word(48'h8000_0000_0000));
        send_word(reply_word(64'h0000_0000_0000_0081, 1'b1));
        send_word(translate_word(48'h0000_0000_0fff));
        send_word(reply_word(64'h000f_0000_0000_0001, 1'b1));
        // full walk down to a 4K page, PS ignored at level 1
        send_word(translate_word('1));
        send_word(reply_word(64'hfff0_ffff_ffff_f007, 1'b1));
        send_word(reply_word(64'hfff0_ffff_ffff_f007, 1'b1));
        send_word(reply_word(64'hfff0_ffff_ffff_f007, 1'b1));
        send_word(reply_word(64'hfff0_ffff_ffff_f087, 1'b1));
        // 1G page
        send_word(translate_word(48'h7fff_ffff_ffff));
        send_word(reply_word(64'h8000_1234_5678_9003, 1'b1));
        send_word(reply_word(64'h0000_ffff_ffff_f083, 1'b1));
        // 2M page
        send_word(translate_word(48'h5555_5555_5555));
        send_word(reply_word(64'h0000_0000_0000_0001, 1'b1));
        send_word(reply_word(64'h0000_ffff_ffff_f005, 1'b1));
        send_word(reply_word(64'h0000_aaaa_aaaa_a081, 1'b1));
        drain();
        load_config('0, 1'b1);
        send_word(translate_word('1));
        send_word(reply_word(64'h7ff0_ffff_ffff_fffb, 1'b1));
        drain();
    endtask

    task automatic random_walk();
        int          pick;
        logic [2:0]  lvl;
        logic [2:0]  stop_at;
        logic [63:0] e;
        bit          ok;
        bit          done;
        steady  = ($urandom_range(0, 7) == 0);
        // an occasional walk is abandoned part way
        stop_at = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(1, 4)) : 3'd0;
        send_word(translate_word(VADDR_W'(rand64())));
        lvl  = LVL_4;
        done = 1'b0;
        while (!done && lvl != stop_at)
        begin
            pick           = $urandom_range(0, 99);
            ok             = 1'b1;
            e              = rand64();
            e[BIT_PRESENT] = 1'b1;
            e[51:48]       = 4'h0;
            if (user_only_now)
                e[BIT_USER] = 1'b1;
            done = 1'b1;
            if (lvl != LVL_1 && pick < (lvl == LVL_4 ? 85 : 70))
            begin
                e[BIT_PS] = 1'b0;
                done      = 1'b0;
            end
            else if (pick < 88)
            begin
                if (lvl != LVL_1)
                    e[BIT_PS] = 1'b1;
            end
            else if (pick < 91)
                ok = 1'b0;
            else if (pick < 94)
                e[BIT_PRESENT] = 1'b0;
            else if (pick < 97)
            begin
                if (user_only_now)
                    e[BIT_USER] = 1'b0;
                else
                    e[BIT_PRESENT] = 1'b0;
            end
            else
                e[51:48] = 4'($urandom_range(1, 15));
            send_word(reply_word(e, ok));
            lvl = lvl - 3'd1;
        end
    endtask

    task automatic random_phase(input logic [ROOT_W-1:0] root, input bit uo);
        int                   target;
        req_t                 w;
        logic [2*ENTRY_W-1:0] raw;
        load_config(root, uo);
        target = result_words + ITEMS_PER_PHASE;
        while (result_words < target)
        begin
            if ($urandom_range(0, 99) < 85)
                random_walk();
            else
            begin
                steady = 1'b0;
                raw    = {rand64(), rand64()};
                w      = raw[$bits(req_t)-1:0];
                send_word(w);
            end
        end
        drain();
    endtask

    initial
    begin : result_sink
        int run;
        int gap;
        bit held;
        held      = 1'b0;
        rsp_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                              : $urandom_range(1, 12);
            rsp_ready <= 1'b1;
            repeat (run) @(posedge clk);
            gap = idle_gap();
            // one long stall while words keep coming, to back up the queue
            if (!held && req_valid && checked_count > 700)
            begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        logic [ROOT_W-1:0] root_pick;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_ROOT_TABLE_FRAME;
        cfg_data      = '0;
        req_valid     = 1'b0;
        req           = '0;
        steady        = 1'b0;
        user_only_now = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        directed_walks();
        random_phase('0, 1'b0);
        random_phase('1, 1'b1);
        root_pick = ROOT_W'(rand64());
        random_phase(root_pick, 1'b0);
        root_pick = ROOT_W'(rand64());
        random_phase(root_pick, 1'b1);
        random_phase('1, 1'b0);
        random_phase('0, 1'b1);
        repeat (10) @(posedge clk);
        $display("tb: %0d words produced results, %0d result words compared",
                 result_words, checked_count);
        $display("tb: exit statuses seen %b, levels seen %b, root frame 0/max/random",
                 status_seen, level_seen);
        if (fail_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
